### design/baro_temp_pressure_compensation_macros.svh
// ---------------------------------------------------------------------------
// Barometer compensation assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// Same-cycle implication.
`define BPTC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BPTC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bptc_pkg.sv
// ---------------------------------------------------------------------------
// Barometer compensation package
// Register codes, carried item fields and 32-bit word helpers.
// ---------------------------------------------------------------------------
package bptc_pkg;

	localparam logic [1:0] REG_TEMP    = 2'd0;
	localparam logic [1:0] REG_PRESS_A = 2'd1;
	localparam logic [1:0] REG_PRESS_B = 2'd2;
	localparam logic [1:0] REG_PRESS_9 = 2'd3;

	localparam logic [31:0] FINE_OFFSET = 32'd64000;
	localparam logic [31:0] P1_BIAS     = 32'd32768;
	localparam logic [31:0] RAW_FULL    = 32'd1048576;
	localparam logic [31:0] P_SCALE     = 32'd3125;
	localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
	localparam logic [31:0] T_ROUND     = 32'd128;

	typedef logic [31:0] word_t;

	// Fields that travel down the main pipeline ahead of the divider.
	typedef struct packed {
		logic [19:0] adc_t;
		logic [19:0] adc_p;
		word_t m1;
		word_t dd;
		word_t v1t;
		word_t m2;
		word_t fine;
		word_t temp;
		word_t pv1;
		word_t qq;
		word_t ma;
		word_t mb;
		word_t mc;
		word_t md;
		word_t v2;
		word_t s;
		word_t pm;
		word_t v1f;
		word_t pn;
		word_t pp;
	} item_t;

	// Fields that ride alongside the divider.
	typedef struct packed {
		word_t temp;
		logic  zero;
		logic  dbl;
	} div_side_t;

	function automatic word_t asr(input word_t x, input logic [4:0] n);
		return word_t'($signed(x) >>> n);
	endfunction

	function automatic word_t sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

### design/bptc_div.sv
// ---------------------------------------------------------------------------
// Pipelined unsigned divider
// 32-bit by 32-bit restoring division, one quotient bit per stage.
// ---------------------------------------------------------------------------
module bptc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [31:0]         dividend,
	input  logic [31:0]         divisor,
	input  bptc_pkg::div_side_t in_side,
	output logic                out_vld,
	output logic [31:0]         quotient,
	output bptc_pkg::div_side_t out_side
);
	import bptc_pkg::*;

	localparam int Stages = 32;

	logic      vld_s  [Stages+1];
	word_t     rem_s  [Stages+1];
	word_t     num_s  [Stages+1];
	word_t     den_s  [Stages+1];
	div_side_t side_s [Stages+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign num_s[0]  = dividend;
	assign den_s[0]  = divisor;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < Stages; g++) begin : g_stage
		logic [32:0] trial;
		logic [32:0] diff;
		logic        take;

		always_comb begin
			trial = {rem_s[g], num_s[g][31]};
			diff  = trial - {1'b0, den_s[g]};
			take  = trial >= {1'b0, den_s[g]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= take ? diff[31:0] : trial[31:0];
				num_s[g+1]  <= {num_s[g][30:0], take};
				den_s[g+1]  <= den_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_vld  = vld_s[Stages];
	assign quotient = num_s[Stages];
	assign out_side = side_s[Stages];

endmodule

### design/baro_temp_pressure_compensation.sv
// ---------------------------------------------------------------------------
// Barometer temperature and pressure compensation
// 32-bit integer compensation of raw temperature and pressure readings.
// ---------------------------------------------------------------------------
//  channel  signals                                  direction
//  in       in_valid, in_stall, raw_temperature,     request in
//           raw_pressure
//  out      out_valid, out_stall, temperature_centi, request out
//           pressure_pa, status
//  cfg      cfg_we, cfg_index, cfg_data              register write
//
// One request enters per cycle while the pipeline is not stalled.
// The pipeline is made of the 32-stage divider plus ten stages before it,
// two after it and the output register.
// Reset clears all valid bits and the coefficient registers.
// A stalled result freezes the whole pipeline, so in_stall follows out_stall while out_valid is high.
// ---------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_macros.svh"

module baro_temp_pressure_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [19:0]        raw_temperature,
	input  logic [19:0]        raw_pressure,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] temperature_centi,
	output logic [31:0]        pressure_pa,
	output logic               status,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import bptc_pkg::*;

	logic [47:0] temp_coeffs_q;
	logic [63:0] press_a_q;
	logic [63:0] press_b_q;
	logic [15:0] press_9_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_a_q     <= '0;
			press_b_q     <= '0;
			press_9_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP:    temp_coeffs_q <= cfg_data[47:0];
				REG_PRESS_A: press_a_q     <= cfg_data;
				REG_PRESS_B: press_b_q     <= cfg_data;
				REG_PRESS_9: press_9_q     <= cfg_data[15:0];
			endcase
		end
	end

	word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = {16'd0, temp_coeffs_q[15:0]};
	assign t2 = sext16(temp_coeffs_q[31:16]);
	assign t3 = sext16(temp_coeffs_q[47:32]);
	assign p1 = {16'd0, press_a_q[15:0]};
	assign p2 = sext16(press_a_q[31:16]);
	assign p3 = sext16(press_a_q[47:32]);
	assign p4 = sext16(press_a_q[63:48]);
	assign p5 = sext16(press_b_q[15:0]);
	assign p6 = sext16(press_b_q[31:16]);
	assign p7 = sext16(press_b_q[47:32]);
	assign p8 = sext16(press_b_q[63:48]);
	assign p9 = sext16(press_9_q);

	logic en;
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	item_t st_s1, st_s2, st_s3, st_s4, st_s5, st_s6, st_s7, st_s8, st_s9, st_s10;
	item_t nx_s1, nx_s2, nx_s3, nx_s4, nx_s5, nx_s6, nx_s7, nx_s8, nx_s9, nx_s10;
	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	word_t adc_t_w, d_w, pv1_w, q_w, x_w;
	always_comb begin
		adc_t_w = {12'd0, st_s1.adc_t};
		d_w     = (adc_t_w >> 4) - t1;
		pv1_w   = asr(st_s4.fine, 5'd1) - FINE_OFFSET;
		q_w     = asr(pv1_w, 5'd2);
		x_w     = asr(asr(st_s6.mc, 5'd3) + asr(st_s6.md, 5'd1), 5'd18);
	end

	always_comb begin
		nx_s1       = '0;
		nx_s1.adc_t = raw_temperature;
		nx_s1.adc_p = raw_pressure;

		nx_s2    = st_s1;
		nx_s2.m1 = ((adc_t_w >> 3) - (t1 << 1)) * t2;
		nx_s2.dd = d_w * d_w;

		nx_s3     = st_s2;
		nx_s3.v1t = asr(st_s2.m1, 5'd11);
		nx_s3.m2  = asr(st_s2.dd, 5'd12) * t3;

		nx_s4      = st_s3;
		nx_s4.fine = st_s3.v1t + asr(st_s3.m2, 5'd14);

		nx_s5      = st_s4;
		nx_s5.temp = asr((st_s4.fine << 2) + st_s4.fine + T_ROUND, 5'd8);
		nx_s5.pv1  = pv1_w;
		nx_s5.qq   = q_w * q_w;

		nx_s6    = st_s5;
		nx_s6.ma = asr(st_s5.qq, 5'd11) * p6;
		nx_s6.mb = st_s5.pv1 * p5;
		nx_s6.mc = p3 * asr(st_s5.qq, 5'd13);
		nx_s6.md = p2 * st_s5.pv1;

		nx_s7    = st_s6;
		nx_s7.v2 = asr(st_s6.ma + (st_s6.mb << 1), 5'd2) + (p4 << 16);
		nx_s7.s  = P1_BIAS + x_w;

		nx_s8    = st_s7;
		nx_s8.pm = st_s7.s * p1;

		nx_s9     = st_s8;
		nx_s9.v1f = asr(st_s8.pm, 5'd15);
		nx_s9.pn  = (RAW_FULL - {12'd0, st_s8.adc_p}) - asr(st_s8.v2, 5'd12);

		nx_s10    = st_s9;
		nx_s10.pp = st_s9.pn * P_SCALE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1  <= nx_s1;
			st_s2  <= nx_s2;
			st_s3  <= nx_s3;
			st_s4  <= nx_s4;
			st_s5  <= nx_s5;
			st_s6  <= nx_s6;
			st_s7  <= nx_s7;
			st_s8  <= nx_s8;
			st_s9  <= nx_s9;
			st_s10 <= nx_s10;
		end
	end

	// Products at or above the sign bit are divided first and doubled after,
	// which keeps the dividend within 32 bits.
	div_side_t div_in_side, div_out_side;
	logic      div_out_vld;
	word_t     div_num, div_quo;

	always_comb begin
		div_in_side.temp = st_s10.temp;
		div_in_side.zero = st_s10.v1f == '0;
		div_in_side.dbl  = st_s10.pp >= SIGN_BIT;
		div_num          = div_in_side.dbl ? st_s10.pp : (st_s10.pp << 1);
	end

	bptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s10),
		.dividend (div_num),
		.divisor  (st_s10.v1f),
		.in_side  (div_in_side),
		.out_vld  (div_out_vld),
		.quotient (div_quo),
		.out_side (div_out_side)
	);

	logic  vld_s43, vld_s44;
	word_t p_s43, a1_s43, b_s43, temp_s43;
	logic  zero_s43;
	word_t p_s44, c_s44, v2_s44, temp_s44;
	logic  zero_s44;
	word_t p_w, p3_w, pres_w;

	always_comb begin
		p_w    = div_out_side.dbl ? (div_quo << 1) : div_quo;
		p3_w   = p_w >> 3;
		pres_w = p_s44 + asr(asr(c_s44, 5'd12) + v2_s44 + p7, 5'd4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s43   <= 1'b0;
			vld_s44   <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s43   <= div_out_vld;
			vld_s44   <= vld_s43;
			out_valid <= vld_s44;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s43    <= p_w;
			a1_s43   <= p3_w * p3_w;
			b_s43    <= (p_w >> 2) * p8;
			temp_s43 <= div_out_side.temp;
			zero_s43 <= div_out_side.zero;

			p_s44    <= p_s43;
			c_s44    <= p9 * (a1_s43 >> 13);
			v2_s44   <= asr(b_s43, 5'd13);
			temp_s44 <= temp_s43;
			zero_s44 <= zero_s43;

			temperature_centi <= temp_s44;
			pressure_pa       <= zero_s44 ? '0 : pres_w;
			status            <= zero_s44;
		end
	end

	`BPTC_ASSERT_IMP(a_err_zero, out_valid && status, pressure_pa == '0, "error result with pressure")
	`BPTC_ASSERT_NXT(a_hold, out_valid && out_stall, $stable(temperature_centi) && out_valid, "stalled result moved")
	`BPTC_ASSERT_NXT(a_enter, in_valid && !in_stall, vld_s1, "accepted request lost at entry")

endmodule

### tb/baro_temp_pressure_compensation_checker.sv
// ----------------------------------------------------------------------------
// Barometer compensation result checker
// Watches the request and result channels and predicts each result from the
// coefficients written so far. Every result is compared with the oldest one
// still waiting.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [19:0]        raw_temperature,
	input  logic [19:0]        raw_pressure,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] temperature_centi,
	input  logic [31:0]        pressure_pa,
	input  logic               status,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	output int                 fail_count,
	output int                 pending_count,
	output int                 result_count,
	output int                 zero_div_count
);
	import bptc_pkg::*;

	typedef struct {
		logic [31:0] temp;
		logic [31:0] press;
		logic        zero_div;
	} reading_t;

	logic [47:0] temp_cal;
	logic [63:0] press_cal_a;
	logic [63:0] press_cal_b;
	logic [15:0] press_cal_9;
	reading_t    expected_readings[$];

	function automatic logic [31:0] sra(input logic [31:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [31:0] sx(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic reading_t compensate(input logic [19:0] adc_t,
			input logic [19:0] adc_p);
		logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] v1, v2, d, q, fine, p, at, ap;
		reading_t r;
		at = {12'd0, adc_t};
		ap = {12'd0, adc_p};
		t1 = {16'd0, temp_cal[15:0]};
		t2 = sx(temp_cal[31:16]);
		t3 = sx(temp_cal[47:32]);
		p1 = {16'd0, press_cal_a[15:0]};
		p2 = sx(press_cal_a[31:16]);
		p3 = sx(press_cal_a[47:32]);
		p4 = sx(press_cal_a[63:48]);
		p5 = sx(press_cal_b[15:0]);
		p6 = sx(press_cal_b[31:16]);
		p7 = sx(press_cal_b[47:32]);
		p8 = sx(press_cal_b[63:48]);
		p9 = sx(press_cal_9);
		v1 = sra(((at >> 3) - (t1 << 1)) * t2, 11);
		d = (at >> 4) - t1;
		v2 = sra(sra(d * d, 12) * t3, 14);
		fine = v1 + v2;
		r.temp = sra(fine * 32'd5 + 32'd128, 8);
		r.press = '0;
		r.zero_div = 1'b0;
		v1 = sra(fine, 1) - 32'd64000;
		q = sra(v1, 2);
		v2 = sra(q * q, 11) * p6;
		v2 = v2 + ((v1 * p5) << 1);
		v2 = sra(v2, 2) + (p4 << 16);
		v1 = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * v1, 1), 18);
		v1 = sra((32'd32768 + v1) * p1, 15);
		if (v1 == '0) begin
			r.zero_div = 1'b1;
			return r;
		end
		p = ((32'd1048576 - ap) - sra(v2, 12)) * 32'd3125;
		if (p < 32'h8000_0000)
			p = (p << 1) / v1;
		else
			p = (p / v1) * 32'd2;
		v1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
		v2 = sra((p >> 2) * p8, 13);
		r.press = p + sra(v1 + v2 + p7, 4);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			temp_cal = '0;
			press_cal_a = '0;
			press_cal_b = '0;
			press_cal_9 = '0;
			expected_readings.delete();
			fail_count = 0;
			result_count = 0;
			zero_div_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_readings.size() == 0) begin
					$error("result with no request waiting");
					fail_count++;
				end else begin
					want = expected_readings.pop_front();
					if (want.zero_div)
						zero_div_count++;
					if (temperature_centi !== want.temp) begin
						$error("temperature_centi: expected %0d, got %0d",
							$signed(want.temp), temperature_centi);
						fail_count++;
					end
					if (pressure_pa !== want.press) begin
						$error("pressure_pa: expected %0d, got %0d",
							want.press, pressure_pa);
						fail_count++;
					end
					if (status !== want.zero_div) begin
						$error("status: expected %0d, got %0d", want.zero_div, status);
						fail_count++;
					end
				end
			end
			// Requests use the coefficients held before this edge.
			if (in_valid && !in_stall)
				expected_readings.push_back(compensate(raw_temperature, raw_pressure));
			if (cfg_we) begin
				case (cfg_index)
					REG_TEMP:    temp_cal = cfg_data[47:0];
					REG_PRESS_A: press_cal_a = cfg_data;
					REG_PRESS_B: press_cal_b = cfg_data;
					REG_PRESS_9: press_cal_9 = cfg_data[15:0];
					default: ;
				endcase
			end
		end
		pending_count = expected_readings.size();
	end

endmodule

### tb/baro_temp_pressure_compensation_test.sv
// ----------------------------------------------------------------------------
// Barometer compensation testbench
// Writes several coefficient sets, sends directed and random raw readings
// under varying valid and stall patterns and leaves checking to the checker.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_test;
	import bptc_pkg::*;

	localparam int LATENCY = 45;
	localparam int WATCHDOG_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [19:0]        raw_temperature;
	logic [19:0]        raw_pressure;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] temperature_centi;
	logic [31:0]        pressure_pa;
	logic               status;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [63:0]        cfg_data;
	int                 fail_count;
	int                 pending_count;
	int                 result_count;
	int                 zero_div_count;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	int                 hold_cycles;
	int                 idle_cycles;
	int                 request_count;

	baro_temp_pressure_compensation u_dut (.*);

	baro_temp_pressure_compensation_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Result side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// The write enable is dropped by the next request that follows.
	task automatic write_coeff(input logic [1:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic send_reading(input logic [19:0] t, input logic [19:0] p);
		cfg_we <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_temperature <= t;
		raw_pressure <= p;
		do
			@(posedge clk);
		while (in_stall);
		request_count++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// Realistic coefficient sets keep the divisor nonzero most of the time.
	task automatic load_typical();
		write_coeff(REG_TEMP, 64'({16'd50, 16'd26435, 16'd27504}));
		write_coeff(REG_PRESS_A, {16'd2855, 16'h2006, 16'hD6D0, 16'd36477});
		write_coeff(REG_PRESS_B, {16'hFFB5, 16'hFFF9, 16'd140, 16'hFF3A});
		write_coeff(REG_PRESS_9, 64'd6000);
	endtask

	task automatic load_random();
		write_coeff(REG_TEMP, {$urandom, $urandom});
		write_coeff(REG_PRESS_A, {$urandom, $urandom});
		write_coeff(REG_PRESS_B, {$urandom, $urandom});
		write_coeff(REG_PRESS_9, {$urandom, $urandom});
	endtask

	task automatic random_readings(input int count);
		repeat (count) begin
			if ($urandom_range(9) < 7)
				send_reading(20'($urandom_range(20'h7FFFF, 20'h8FFFF)),
					20'($urandom_range(20'h40000, 20'h6FFFF)));
			else
				send_reading(20'($urandom), 20'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_temperature = '0;
		raw_pressure = '0;
		cfg_we = 1'b0;
		cfg_index = REG_TEMP;
		cfg_data = '0;
		hold_cycles = 0;
		idle_cycles = 0;
		request_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All coefficients zero after reset: the divisor is zero.
		send_reading('0, '0);
		send_reading('1, '1);
		drain_results();

		load_typical();
		send_reading(20'd519888, 20'd415148);
		send_reading('0, '0);
		send_reading('1, '1);
		send_reading('0, '1);
		send_reading('1, '0);
		send_reading(20'h55555, 20'hAAAAA);
		send_reading(20'hAAAAA, 20'h55555);
		drain_results();

		// Extreme coefficients in every field.
		write_coeff(REG_TEMP, 64'({16'h7FFF, 16'h8000, 16'hFFFF}));
		write_coeff(REG_PRESS_A, '1);
		write_coeff(REG_PRESS_B, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
		write_coeff(REG_PRESS_9, 64'h8000);
		send_reading('0, '1);
		send_reading('1, '0);
		send_reading(20'h80000, 20'h80000);
		drain_results();
		write_coeff(REG_TEMP, 64'({16'h8000, 16'h7FFF, 16'h0000}));
		write_coeff(REG_PRESS_A, 64'h7FFF_7FFF_8000_0001);
		write_coeff(REG_PRESS_B, '1);
		write_coeff(REG_PRESS_9, 64'h7FFF);
		send_reading('1, '1);
		send_reading(20'h12345, 20'hFEDCB);
		drain_results();

		// Long hold-off on results while requests keep coming.
		load_typical();
		hold_cycles = 200;
		random_readings(80);
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 59 : 0;
			recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 11 : 0;
			load_typical();
			random_readings(200);
			drain_results();
			load_random();
			random_readings(100);
			drain_results();
		end

		$display("Sent %0d readings over typical, extreme and random coefficients;",
			request_count);
		$display("checked %0d results, %0d with a zero pressure divisor.",
			result_count, zero_div_count);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
